// File: hdl/pcu_pkg.sv
// Shared constants and types for the pinhole projection and cull unit.
`timescale 1ns / 1ps

package pcu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUOT_BITS     = 33;   // quotient bits kept; larger quotients saturate
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_FOV   = 3'd5;

    localparam logic [31:0] MAX_DEPTH_RST = 32'd196608;
    localparam logic [31:0] TAN_FOV_RST   = 32'd78103;

    typedef struct packed {
        logic neg_u;    // quotient sign for u
        logic neg_v;    // quotient sign for v
        logic zero;     // depth is zero
        logic x_neg;
        logic y_neg;
    } t_side;

endpackage

// File: hdl/pinhole_project_and_cull_unit.sv
// Top level: pinhole projection of camera points with a view-cone visibility test.
`timescale 1ns / 1ps
// Throughput: one point per cycle while the output is not stalled; the two dividers set the depth.
// The whole pipeline stalls together only while the output holds a result not taken.
// Reset (synchronous, active low) clears all valid bits and loads register
// defaults: focal and center zero, max_depth 3.0, tan_half_fov tan 50 degrees.

module pinhole_project_and_cull_unit #(
    parameter int FRAC_BITS = pcu_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,  // point_x, point_y, point_z
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,  // image_u, image_v
    output logic [1:0]                    m_axis_tuser   // visible, zero_depth_fault
);
    localparam int QB  = pcu_pkg::QUOT_BITS;
    localparam int L   = QB + 1;          // divider latency
    localparam int VD  = L - 3;           // extra delay for the visibility flag
    localparam logic [31:0] MIN_DEPTH = 32'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

    // ---------------- configuration registers ----------------
    logic [31:0] r_focal_x, r_focal_y, r_center_x, r_center_y, r_max_depth, r_tan;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x   <= '0;
            r_focal_y   <= '0;
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_max_depth <= pcu_pkg::MAX_DEPTH_RST;
            r_tan       <= pcu_pkg::TAN_FOV_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pcu_pkg::REG_FOCAL_X:   r_focal_x   <= i_cfg_data;
                pcu_pkg::REG_FOCAL_Y:   r_focal_y   <= i_cfg_data;
                pcu_pkg::REG_CENTER_X:  r_center_x  <= i_cfg_data;
                pcu_pkg::REG_CENTER_Y:  r_center_y  <= i_cfg_data;
                pcu_pkg::REG_MAX_DEPTH: r_max_depth <= i_cfg_data;
                pcu_pkg::REG_TAN_FOV:   r_tan       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    // all stages move together unless the output register holds an untaken result
    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // valid bits: stage 1, stage 2, then L divider stages
    logic          r_v1, r_v2;
    logic [L-1:0]  r_vd;

    // ---------------- stage 1: capture ----------------
    logic signed [31:0] r1_x, r1_y, r1_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x <= s_axis_tdata[31:0];
            r1_y <= s_axis_tdata[63:32];
            r1_z <= s_axis_tdata[95:64];
        end
    end

    // ---------------- stage 2: products ----------------
    logic [31:0] w_ax, w_ay, w_az;
    assign w_ax = r1_x[31] ? 32'(-r1_x) : 32'(r1_x);
    assign w_ay = r1_y[31] ? 32'(-r1_y) : 32'(r1_y);
    assign w_az = r1_z[31] ? 32'(-r1_z) : 32'(r1_z);

    logic [63:0]    r2_pu, r2_pv, r2_tz, r2_xx, r2_yy;
    logic [31:0]    r2_az;
    logic           r2_zok;
    pcu_pkg::t_side r2_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pu  <= 64'(r_focal_x) * 64'(w_ax);
            r2_pv  <= 64'(r_focal_y) * 64'(w_ay);
            r2_az  <= w_az;
            r2_tz  <= 64'(r_tan) * 64'(w_az);
            r2_xx  <= 64'(w_ax) * 64'(w_ax);
            r2_yy  <= 64'(w_ay) * 64'(w_ay);
            // strictly between min and max depth
            r2_zok <= (r1_z > $signed(MIN_DEPTH)) && (32'(r1_z) < r_max_depth);
            r2_side.neg_u <= r1_x[31] != r1_z[31];
            r2_side.neg_v <= r1_y[31] != r1_z[31];
            r2_side.zero  <= r1_z == '0;
            r2_side.x_neg <= r1_x[31];
            r2_side.y_neg <= r1_y[31];
        end
    end

    // ---------------- dividers ----------------
    logic [QB-1:0] w_qu, w_qv;
    logic          w_ovu, w_ovv;

    pcu_div u_div_u (
        .i_clk(i_clk), .i_en(w_en), .i_dividend(r2_pu), .i_divisor(r2_az),
        .o_quot(w_qu), .o_ovf(w_ovu)
    );
    pcu_div u_div_v (
        .i_clk(i_clk), .i_en(w_en), .i_dividend(r2_pv), .i_divisor(r2_az),
        .o_quot(w_qv), .o_ovf(w_ovv)
    );

    // sideband delay alongside the dividers
    pcu_pkg::t_side r_sd [L];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r2_side;
            for (int i = 1; i < L; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    // ---------------- view cone test: stages 3..5 ----------------
    logic [63:0]  r3_s, r3_ll, r3_lh, r3_hh;
    logic         r3_zok, r4_zok, r5_vis;
    logic [127:0] r4_lhs, r4_rhs;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_s   <= r2_xx + r2_yy;
            r3_ll  <= 64'(r2_tz[31:0])  * 64'(r2_tz[31:0]);
            r3_lh  <= 64'(r2_tz[31:0])  * 64'(r2_tz[63:32]);
            r3_hh  <= 64'(r2_tz[63:32]) * 64'(r2_tz[63:32]);
            r3_zok <= r2_zok;
            r4_lhs <= 128'(r3_s) << (2 * FRAC_BITS);
            r4_rhs <= (128'(r3_hh) << 64) + (128'(r3_lh) << 33) + 128'(r3_ll);
            r4_zok <= r3_zok;
            r5_vis <= r4_zok && (r4_lhs <= r4_rhs);
        end
    end

    logic [VD-1:0] r_visd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_visd <= {r_visd[VD-2:0], r5_vis};
        end
    end

    // ---------------- final stage: sign, center, saturate ----------------
    function automatic logic [31:0] pcu_finish(
        input logic [QB-1:0] q, input logic ovf, input logic neg,
        input logic [31:0] center
    );
        logic [QB:0]          mag;
        logic signed [QB+2:0] val;
        begin
            mag = ovf ? (QB+1)'(1) << QB : (QB+1)'(q);
            val = neg ? -$signed((QB+3)'(mag)) : $signed((QB+3)'(mag));
            val = val + $signed((QB+3)'(center));
            if (val > $signed((QB+3)'(32'h7FFF_FFFF)))
                pcu_finish = 32'h7FFF_FFFF;
            else if (val < -$signed((QB+3)'(33'h1_0000_0000) >>> 1))
                pcu_finish = 32'h8000_0000;
            else
                pcu_finish = val[31:0];
        end
    endfunction

    pcu_pkg::t_side w_fs;
    assign w_fs = r_sd[L-1];

    logic [31:0] r_u, r_v;
    logic        r_vis, r_fault;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_fs.zero) begin
                r_u <= w_fs.x_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                r_v <= w_fs.y_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                r_u <= pcu_finish(w_qu, w_ovu, w_fs.neg_u, r_center_x);
                r_v <= pcu_finish(w_qv, w_ovv, w_fs.neg_v, r_center_y);
            end
            r_vis   <= r_visd[VD-1];
            r_fault <= w_fs.zero;
        end
    end

    // valid chain
    logic r_vo;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vd <= '0;
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_vd <= {r_vd[L-2:0], r_v2};
            r_vo <= r_vd[L-1];
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {r_v, r_u};
    assign m_axis_tuser  = {r_fault, r_vis};

    // ---------------- checks ----------------
    a_fault_not_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("zero depth point reported visible");

    a_fault_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            (m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000))
        else $error("zero depth u not saturated");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vd) && $stable(r_visd))
        else $error("pipeline moved during stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && r_vd == '0)
        else $error("valid bits not cleared by reset");

endmodule

// File: hdl/pcu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps

module pcu_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [63:0]                    i_dividend,
    input  logic [31:0]                    i_divisor,
    output logic [pcu_pkg::QUOT_BITS-1:0]  o_quot,
    output logic                           o_ovf
);
    localparam int QB = pcu_pkg::QUOT_BITS;
    localparam int RW = 65;

    logic [RW-1:0] r_rem [QB+1];
    logic [31:0]   r_d   [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_ovf [QB+1];

    // stage 0: overflow when quotient would need more than QB bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_dividend);
            r_d[0]   <= i_divisor;
            r_q[0]   <= '0;
            r_ovf[0] <= (RW'(i_dividend) >> QB) >= RW'(i_divisor);
        end
    end

    for (genvar g = 0; g < QB; g++) begin : g_stage
        localparam int B = QB - 1 - g;
        logic [RW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = RW'(r_d[g]) << B;
        assign w_ge = r_rem[g] >= w_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= w_ge ? r_rem[g] - w_sh : r_rem[g];
                r_d[g+1]   <= r_d[g];
                r_ovf[g+1] <= r_ovf[g];
                r_q[g+1]   <= r_q[g] | (QB'(w_ge) << B);
            end
        end
    end

    assign o_quot = r_q[QB];
    assign o_ovf  = r_ovf[QB];

endmodule

// File: sim/tb.sv
// Testbench for the pinhole projection and cull unit: directed and random points.
`timescale 1ns / 1ps

module tb;

    localparam int FB = pcu_pkg::FRAC_BITS_DEF;
    // rounded 0.01 in fixed point
    localparam logic [31:0] MIN_DEPTH = ((32'd1 << FB) + 32'd50) / 32'd100;
    // index past the last register; writes to it must be dropped
    localparam logic [pcu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
    localparam int LATENCY = pcu_pkg::QUOT_BITS + 4;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        vis;
        logic        fault;
    } t_pixel;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [pcu_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                   i_cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [95:0]                   s_axis_tdata = '0;   // point_x, point_y, point_z
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [63:0]                   m_axis_tdata;        // image_u, image_v
    logic [1:0]                    m_axis_tuser;        // visible, zero_depth_fault

    // shadow copy of the register file
    logic [31:0] fx, fy, cx, cy, far_z, tan_fov;

    t_pixel pixel_q[$];
    int     n_fail = 0;
    bit     rx_burst = 1'b0;   // when set, the sink never stalls

    always #10 i_clk = ~i_clk;

    pinhole_project_and_cull_unit DUT (.*);

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] project_axis(logic [31:0] focal, logic [31:0] coord,
                                                 logic [31:0] depth, logic [31:0] center);
        logic signed [63:0] cs, ds;
        logic [63:0]        mc, md, mag;
        logic signed [66:0] val;
        if (depth == 32'd0)
            return coord[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        cs  = $signed(coord);
        ds  = $signed(depth);
        mc  = cs < 0 ? -cs : cs;
        md  = ds < 0 ? -ds : ds;
        mag = ({32'd0, focal} * mc) / md;
        if (mag > (64'd1 << 40))
            mag = 64'd1 << 40;
        val = $signed({3'b000, mag});
        if (coord[31] != depth[31])
            val = -val;
        val = val + $signed({35'd0, center});
        if (val > 67'sd2147483647)
            val = 67'sd2147483647;
        if (val < -67'sd2147483648)
            val = -67'sd2147483648;
        return val[31:0];
    endfunction

    function automatic logic in_cone(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic signed [63:0] xs, ys;
        logic [63:0]        ax, ay, s, p;
        logic [127:0]       lhs, rhs;
        if ($signed(z) <= $signed(MIN_DEPTH))
            return 1'b0;
        if (z >= far_z)
            return 1'b0;
        xs  = $signed(x);
        ys  = $signed(y);
        ax  = xs < 0 ? -xs : xs;
        ay  = ys < 0 ? -ys : ys;
        s   = ax * ax + ay * ay;
        lhs = {64'd0, s} << (2 * FB);
        p   = {32'd0, tan_fov} * {32'd0, z};
        rhs = {64'd0, p} * {64'd0, p};
        return lhs <= rhs;
    endfunction

    function automatic t_pixel predict_pixel(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_pixel r;
        r.u     = project_axis(fx, x, z, cx);
        r.v     = project_axis(fy, y, z, cy);
        r.vis   = in_cone(x, y, z);
        r.fault = (z == 32'd0);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ---------------------------------------------------------------
    // Sink: random tready and the result checker
    // ---------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pixel_q.size() == 0) begin
                $error("result transaction with nothing expected");
                n_fail++;
            end else begin
                t_pixel e;
                e = pixel_q.pop_front();
                if (m_axis_tdata[31:0] !== e.u) begin
                    $error("image_u expected %h got %h", e.u, m_axis_tdata[31:0]);
                    n_fail++;
                end
                if (m_axis_tdata[63:32] !== e.v) begin
                    $error("image_v expected %h got %h", e.v, m_axis_tdata[63:32]);
                    n_fail++;
                end
                if (m_axis_tuser[0] !== e.vis) begin
                    $error("visible expected %b got %b", e.vis, m_axis_tuser[0]);
                    n_fail++;
                end
                if (m_axis_tuser[1] !== e.fault) begin
                    $error("zero_depth_fault expected %b got %b", e.fault, m_axis_tuser[1]);
                    n_fail++;
                end
            end
        end
        if (!i_rst_n || rx_burst) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = gap_len();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // ---------------------------------------------------------------
    // Shared tasks
    // ---------------------------------------------------------------
    task automatic cfg_write(logic [pcu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            pcu_pkg::REG_FOCAL_X:   fx      = data;
            pcu_pkg::REG_FOCAL_Y:   fy      = data;
            pcu_pkg::REG_CENTER_X:  cx      = data;
            pcu_pkg::REG_CENTER_Y:  cy      = data;
            pcu_pkg::REG_MAX_DEPTH: far_z   = data;
            pcu_pkg::REG_TAN_FOV:   tan_fov = data;
            default: ;
        endcase
    endtask

    task automatic load_camera(logic [31:0] fxv, logic [31:0] fyv, logic [31:0] cxv,
                               logic [31:0] cyv, logic [31:0] farv, logic [31:0] tanv);
        cfg_write(pcu_pkg::REG_FOCAL_X, fxv);
        cfg_write(pcu_pkg::REG_FOCAL_Y, fyv);
        cfg_write(pcu_pkg::REG_CENTER_X, cxv);
        cfg_write(pcu_pkg::REG_CENTER_Y, cyv);
        cfg_write(pcu_pkg::REG_MAX_DEPTH, farv);
        cfg_write(pcu_pkg::REG_TAN_FOV, tanv);
        @(posedge i_clk);
    endtask

    // one point transaction, then an optional idle gap
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pixel_q.push_back(predict_pixel(x, y, z));
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // let the pipeline empty before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0003_0000) - 32'h0001_8000;  // about +-1.5
            2: return {{8{1'b0}}, 24'($urandom)} ^ {32{1'($urandom)}};
            default: return $urandom_range(32'h0000_8000) - 32'h0000_4000;
        endcase
    endfunction

    function automatic logic [31:0] rand_depth();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom;
            2: return -$urandom_range(32'h0004_0000);
            3: return MIN_DEPTH + $urandom_range(2) - 1;
            4: return far_z + $urandom_range(2) - 1;
            default: return $urandom_range(32'h0004_0000, 32'h0000_0100);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_defaults();
        // default registers: u and v follow center (zero) unless saturated
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000);
        send_point(32'h0003_0000, 32'h0000_0000, 32'h0001_0000);
        drain();
    endtask

    task automatic test_directed();
        load_camera(32'd500 << 16, 32'd480 << 16, 32'd320 << 16, 32'd240 << 16,
                    32'd10 << 16, 32'h0001_0000);
        cfg_write(REG_UNUSED, 32'hDEAD_BEEF);
        cfg_write(REG_UNUSED + 3'd1, 32'h1234_5678);
        // zero depth with each coordinate sign
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'd0);
        send_point(32'hFFFF_0000, 32'h0001_0000, 32'd0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'd0);
        // depth right at and just above the near limit
        send_point(32'd0, 32'd0, MIN_DEPTH);
        send_point(32'd0, 32'd0, MIN_DEPTH + 32'd1);
        // depth right at and below the far limit
        send_point(32'd0, 32'd0, far_z);
        send_point(32'd0, 32'd0, far_z - 32'd1);
        // negative depth
        send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        // exactly on the cone edge, just outside, just inside
        send_point(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        send_point(32'h0001_0001, 32'h0000_0000, 32'h0001_0000);
        send_point(32'h0000_FFFF, 32'h0000_0000, 32'h0001_0000);
        // coordinate extremes with tiny and extreme depths; a tiny depth forces saturation
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_1000);
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) rx_burst = ($urandom_range(3) == 0);
            send_point(rand_coord(), rand_coord(), rand_depth());
        end
        rx_burst = 1'b0;
        drain();
    endtask

    task automatic test_random_settings();
        load_camera(32'd600 << 16, 32'd600 << 16, 32'd320 << 16, 32'd240 << 16,
                    32'd3 << 16, 32'd78103);
        test_random(100);
        // all registers at their top code
        load_camera('1, '1, '1, '1, '1, '1);
        test_random(100);
        // all registers at zero
        load_camera('0, '0, '0, '0, '0, '0);
        test_random(60);
        load_camera($urandom, $urandom, $urandom, $urandom,
                    $urandom_range(32'h0008_0000), $urandom_range(32'h0004_0000));
        test_random(140);
    endtask

    initial begin
        fx = '0; fy = '0; cx = '0; cy = '0;
        far_z = pcu_pkg::MAX_DEPTH_RST;
        tan_fov = pcu_pkg::TAN_FOV_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_random_settings();
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
